@@ rtl/irfe_pkg.sv @@
package irfe_pkg;

   localparam int MAX_DIM_DEFAULT = 256;
   localparam int DIM_CFG_W       = 9;
   localparam int DIM_RESET       = 256;
   localparam int CHAN_W          = 8;
   localparam int REG_IDX_W       = 2;

   // output buffer: three slots so that reads stream while one result waits
   localparam int RSP_DEPTH  = 3;
   localparam int RSP_PTR_W  = 2;
   localparam int RSP_CNT_W  = 2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;

   typedef enum logic [1:0] {
      MODE_ROT_LEFT  = 2'd0,
      MODE_ROT_RIGHT = 2'd1,
      MODE_FLIP_V    = 2'd2,
      MODE_FLIP_H    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   localparam int PIX_W = $bits(pixel_type);

   typedef struct packed {
      pixel_type pixel;
      logic      last;
   } rsp_entry_type;

endpackage

@@ rtl/irfe_if.sv @@
interface irfe_req_if import irfe_pkg::*;;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface irfe_rsp_if import irfe_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              last_pixel;

   modport source (output valid, red_out, green_out, blue_out, last_pixel, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

interface irfe_csr_if import irfe_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [REG_IDX_W-1:0] reg_index;
   logic [DIM_CFG_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/irfe_ram.sv @@
module irfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/irfe_waddr.sv @@
module irfe_waddr import irfe_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   restart,
   input  logic [$clog2(MAX_DIM+1)-1:0]           width_eff,
   input  logic [$clog2(MAX_DIM+1)-1:0]           height_eff,
   input  mode_type                               mode,
   input  logic                                   wr_accept,
   input  pixel_type                              wr_pixel,
   output logic                                   mem_wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     mem_wr_addr,
   output pixel_type                              mem_wr_data
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic              vld_ff, vld_in;
   logic [ADDR_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] add_ff, add_in;
   pixel_type         data_ff;

   logic [CNT_W-1:0]  w_m1, h_m1, col_rev, row_rev;
   logic [CNT_W-1:0]  mul_a, addend;
   logic [DIM_W-1:0]  mul_b;
   logic              col_wrap, row_wrap;

   assign w_m1    = CNT_W'(width_eff - 1'b1);
   assign h_m1    = CNT_W'(height_eff - 1'b1);
   assign col_rev = w_m1 - col_ff;
   assign row_rev = h_m1 - row_ff;

   // target = mul_a * mul_b + addend, per transform
   always_comb begin
      case (mode)
         MODE_ROT_LEFT: begin
            mul_a  = col_rev;
            mul_b  = height_eff;
            addend = row_ff;
         end
         MODE_ROT_RIGHT: begin
            mul_a  = col_ff;
            mul_b  = height_eff;
            addend = row_rev;
         end
         MODE_FLIP_V: begin
            mul_a  = row_rev;
            mul_b  = width_eff;
            addend = col_ff;
         end
         default: begin
            mul_a  = row_ff;
            mul_b  = width_eff;
            addend = col_rev;
         end
      endcase
   end

   assign prod_in = ADDR_W'(mul_a * mul_b);
   assign add_in  = {{(ADDR_W-CNT_W){1'b0}}, addend};

   assign col_wrap = (col_ff == w_m1);
   assign row_wrap = (row_ff == h_m1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (wr_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign vld_in = wr_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_accept) begin
         prod_ff <= prod_in;
         add_ff  <= add_in;
         data_ff <= wr_pixel;
      end
   end

   assign mem_wr_en   = vld_ff;
   assign mem_wr_addr = prod_ff + add_ff;
   assign mem_wr_data = data_ff;

endmodule

@@ rtl/irfe_rsp_fifo.sv @@
module irfe_rsp_fifo import irfe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_entry_type        push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rsp_entry_type        pop_entry,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_entry_type        slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RSP_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 pop;

   assign pop = pop_valid && pop_ready;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = slot_ff[rptr_ff];
   assign count     = cnt_ff;

endmodule

@@ rtl/image_rotate_flip_engine.sv @@
// Frame rotate / flip engine for RGB pixels.
//
// req_ch carries one command per beat: cmd write stores the next pixel of the
// input frame (raster order) at its place in the transformed frame; cmd read
// returns the next pixel of the transformed frame on rsp_ch, with last_pixel
// set on the final one. Rotations swap output width and height.
// csr_ch sets frame_width, frame_height and transform_mode; any write to one
// of them restarts both raster counters, the frame memory keeps its data.
// Write only while no read result is outstanding.
//
// Throughput: one beat per cycle while req_ch ready is high, reads and writes
// in any mix. A write goes through one multiply stage and lands in the frame
// memory on the edge after acceptance; a read issued meanwhile picks up the
// pending data by bypass. Read path: registered memory read, output buffer.
// A three-slot output buffer decouples rsp_ch: req_ch keeps taking beats while
// results wait, and drops ready only once the buffer plus the read in flight
// would fill it.
// Reset: counters clear, dims return to 256 (capped at MAX_DIM), mode rotate
// left. Frame memory content is undefined until written; no clearing pass.
module image_rotate_flip_engine import irfe_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   irfe_req_if.sink   req_ch,
   irfe_rsp_if.source rsp_ch,
   irfe_csr_if.sink   csr_ch
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int CMP_W  = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
   localparam int OCC_W  = RSP_CNT_W + 1;

   // map a raw dimension onto 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
      logic [CMP_W-1:0] ve;
      ve = CMP_W'(v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (ve > CMP_W'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(ve);
      end
   endfunction

   // ---------------------------------------------------------------- config
   logic [DIM_W-1:0] width_ff, height_ff;
   mode_type         mode_ff;
   logic             csr_fire;
   logic             restart;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign restart      = csr_fire && (csr_ch.reg_index inside
                         {REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_TRANSFORM_MODE});

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(DIM_CFG_W'(DIM_RESET));
         height_ff <= clamp_dim(DIM_CFG_W'(DIM_RESET));
         mode_ff   <= MODE_ROT_LEFT;
      end else if (csr_fire) begin
         case (csr_ch.reg_index)
            REG_FRAME_WIDTH:    width_ff  <= clamp_dim(csr_ch.wr_data);
            REG_FRAME_HEIGHT:   height_ff <= clamp_dim(csr_ch.wr_data);
            REG_TRANSFORM_MODE: mode_ff   <= mode_type'(csr_ch.wr_data[1:0]);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- req side
   logic      req_fire, wr_accept, rd_accept;
   pixel_type req_pixel;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign wr_accept = req_fire && (req_ch.cmd == CMD_WRITE);
   assign rd_accept = req_fire && (req_ch.cmd == CMD_READ);
   assign req_pixel = '{red: req_ch.red_in, green: req_ch.green_in, blue: req_ch.blue_in};

   // write address pipeline: counters, multiply stage, memory write
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   pixel_type         mem_wr_data;

   irfe_waddr #(.MAX_DIM(MAX_DIM)) u_waddr (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .width_eff   (width_ff),
      .height_eff  (height_ff),
      .mode        (mode_ff),
      .wr_accept   (wr_accept),
      .wr_pixel    (req_pixel),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // read position walks the output raster; output dims swap on rotation
   logic [ADDR_W-1:0] rpos_ff, rpos_in;
   logic [CNT_W-1:0]  rcol_ff, rcol_in;
   logic [CNT_W-1:0]  rrow_ff, rrow_in;
   logic [DIM_W-1:0]  out_w, out_h;
   logic              rcol_wrap, rrow_wrap, rd_last;

   always_comb begin
      if (mode_ff == MODE_ROT_LEFT || mode_ff == MODE_ROT_RIGHT) begin
         out_w = height_ff;
         out_h = width_ff;
      end else begin
         out_w = width_ff;
         out_h = height_ff;
      end
   end

   assign rcol_wrap = (rcol_ff == CNT_W'(out_w - 1'b1));
   assign rrow_wrap = (rrow_ff == CNT_W'(out_h - 1'b1));
   assign rd_last   = rcol_wrap && rrow_wrap;

   always_comb begin
      rpos_in = rpos_ff;
      rcol_in = rcol_ff;
      rrow_in = rrow_ff;
      if (restart) begin
         rpos_in = '0;
         rcol_in = '0;
         rrow_in = '0;
      end else if (rd_accept) begin
         if (rd_last) begin
            rpos_in = '0;
            rcol_in = '0;
            rrow_in = '0;
         end else if (rcol_wrap) begin
            rpos_in = rpos_ff + 1'b1;
            rcol_in = '0;
            rrow_in = rrow_ff + 1'b1;
         end else begin
            rpos_in = rpos_ff + 1'b1;
            rcol_in = rcol_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ frame store
   pixel_type mem_rd_data;

   irfe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_DIM * MAX_DIM)) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (rd_accept),
      .rd_addr (rpos_ff),
      .rd_data (mem_rd_data)
   );

   // bypass a write that lands on the same edge as the read
   logic      fwd_hit_ff, fwd_hit_in;
   pixel_type fwd_data_ff;
   logic      rd_pend_ff;
   logic      rd_last_ff;

   assign fwd_hit_in = mem_wr_en && (mem_wr_addr == rpos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rpos_ff    <= '0;
         rcol_ff    <= '0;
         rrow_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rpos_ff    <= rpos_in;
         rcol_ff    <= rcol_in;
         rrow_ff    <= rrow_in;
         rd_pend_ff <= rd_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_accept) begin
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= mem_wr_data;
         rd_last_ff  <= rd_last;
      end
   end

   // ------------------------------------------------------------- rsp side
   rsp_entry_type        push_entry, pop_entry;
   logic [RSP_CNT_W-1:0] buf_count;
   logic [OCC_W-1:0]     occupancy;

   assign push_entry.pixel = fwd_hit_ff ? fwd_data_ff : mem_rd_data;
   assign push_entry.last  = rd_last_ff;

   irfe_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (rd_pend_ff),
      .push_entry (push_entry),
      .pop_valid  (rsp_ch.valid),
      .pop_ready  (rsp_ch.ready),
      .pop_entry  (pop_entry),
      .count      (buf_count)
   );

   // hold off new beats once buffered plus in-flight results fill the buffer
   assign occupancy    = OCC_W'(buf_count) + OCC_W'(rd_pend_ff);
   assign req_ch.ready = (occupancy < OCC_W'(RSP_DEPTH));

   assign rsp_ch.red_out    = pop_entry.pixel.red;
   assign rsp_ch.green_out  = pop_entry.pixel.green;
   assign rsp_ch.blue_out   = pop_entry.pixel.blue;
   assign rsp_ch.last_pixel = pop_entry.last;

endmodule
